// ----- hw/rtl/gdc_pkg.sv -----
// ----------------------------------------------------------------------------
// gdc_pkg
// Types, constants and calendar helper functions shared by the Gregorian
// date calendar unit.
// ----------------------------------------------------------------------------
package gdc_pkg;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int OFFSET_W = 16;
  localparam int ORD_W    = 9;
  localparam int CFG_W    = 14;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_DAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MONTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_YEAR  = 2'd2;

  localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
  localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
  localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;

  localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W:0]   MONTH_LAST = 5'd12;

  localparam logic [DAY_W-1:0] DAYS_LONG_MONTH = 5'd31;
  localparam logic [DAY_W-1:0] DAYS_LEAP_FEB   = 5'd29;

  // Reciprocal of 25 scaled by 2^20, rounded up; exact for 14-bit years.
  localparam logic [15:0] RECIP_25 = 16'd41944;
  localparam int RECIP_SHIFT = 20;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Days before the first of each month in a common year. Months above
  // twelve count as 31 days long, so the sums keep going past December.
  localparam logic [ORD_W-1:0] CUM_DAYS [16] = '{
    9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd396, 9'd427
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_STEP,
    ST_COMMIT,
    ST_ORD_WAIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic                req_type;
    logic [OFFSET_W-1:0] days_offset;
    logic [DAY_W-1:0]    cmp_day;
    logic [MONTH_W-1:0]  cmp_month;
    logic [YEAR_W-1:0]   cmp_year;
  } req_t;

  typedef struct packed {
    logic [DAY_W-1:0]   res_day;
    logic [MONTH_W-1:0] res_month;
    logic [YEAR_W-1:0]  res_year;
    logic [ORD_W-1:0]   day_of_year;
    logic               is_earlier;
    logic               is_same;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic days_zero;
    logic out_free;
  } dp_status_t;

  // Leap year test: divisible by 4 but not 100, or divisible by 400.
  // Uses 100 = 4 * 25 and 400 = 16 * 25.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [29:0]       prod;
    logic [9:0]        q;
    logic [YEAR_W-1:0] q25;
    logic              div25;
    prod  = 30'(y) * 30'(RECIP_25);
    q     = prod[29:RECIP_SHIFT];
    q25   = {q, 4'b0000} + 14'({q, 3'b000}) + 14'(q);
    div25 = (q25 == y);
    return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [MONTH_W-1:0] idx;
    idx = m - 4'd1;
    if ((m == 4'd0) || ({1'b0, m} > MONTH_LAST)) begin
      return DAYS_LONG_MONTH;
    end else if ((m == MONTH_FEB) && leap) begin
      return DAYS_LEAP_FEB;
    end else begin
      return MONTH_LEN[idx];
    end
  endfunction

endpackage

// ----- hw/rtl/gdc_ctrl.sv -----
// ----------------------------------------------------------------------------
// gdc_ctrl
// Sequencer for the calendar unit: takes a request word, steps the working
// date one day per cycle, commits it and hands the result to the output.
// ----------------------------------------------------------------------------
module gdc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  gdc_pkg::dp_status_t status,
  output gdc_pkg::dp_cmd_t    cmd
);

  gdc_pkg::state_t state;
  gdc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      gdc_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = gdc_pkg::ST_SETTLE;
        end
      end
      // The leap flag of the working year is registered during this cycle.
      gdc_pkg::ST_SETTLE: begin
        state_next = gdc_pkg::ST_STEP;
      end
      gdc_pkg::ST_STEP: begin
        if (status.days_zero) begin
          state_next = gdc_pkg::ST_COMMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      gdc_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = gdc_pkg::ST_ORD_WAIT;
      end
      // The leap flag of the stored year catches up with the commit here.
      gdc_pkg::ST_ORD_WAIT: begin
        state_next = gdc_pkg::ST_RESULT;
      end
      gdc_pkg::ST_RESULT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = gdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gdc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/gdc_datapath.sv -----
// ----------------------------------------------------------------------------
// gdc_datapath
// Stored date, working date with day-by-day increment, leap flags, day of
// year and compare logic, and the output word register.
// ----------------------------------------------------------------------------
module gdc_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [gdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gdc_pkg::CFG_W-1:0]            cfg_data,
  input  gdc_pkg::req_t                        req_word,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output gdc_pkg::rsp_t                        rsp_word,
  input  gdc_pkg::dp_cmd_t                     cmd,
  output gdc_pkg::dp_status_t                  status
);

  logic [gdc_pkg::DAY_W-1:0]    cur_day;
  logic [gdc_pkg::MONTH_W-1:0]  cur_month;
  logic [gdc_pkg::YEAR_W-1:0]   cur_year;
  logic                         cur_leap;

  logic [gdc_pkg::DAY_W-1:0]    work_day;
  logic [gdc_pkg::MONTH_W-1:0]  work_month;
  logic [gdc_pkg::YEAR_W-1:0]   work_year;
  logic                         work_leap;
  logic [gdc_pkg::OFFSET_W-1:0] days_left;

  logic                         peek;
  logic [gdc_pkg::DAY_W-1:0]    cmp_day;
  logic [gdc_pkg::MONTH_W-1:0]  cmp_month;
  logic [gdc_pkg::YEAR_W-1:0]   cmp_year;

  logic [gdc_pkg::DAY_W-1:0]    day_next;
  logic [gdc_pkg::MONTH_W-1:0]  month_next;
  logic [gdc_pkg::YEAR_W-1:0]   year_next;
  logic [gdc_pkg::DAY_W:0]      day_inc;
  logic [gdc_pkg::MONTH_W:0]    month_inc;
  logic [gdc_pkg::DAY_W-1:0]    month_len;

  logic [gdc_pkg::ORD_W-1:0]    ordinal;
  logic                         earlier;
  logic                         same;

  // One calendar day forward from the working date.
  always_comb begin
    month_len  = gdc_pkg::month_days(work_month, work_leap);
    day_inc    = {1'b0, work_day} + 6'd1;
    month_inc  = {1'b0, work_month} + 5'd1;
    day_next   = day_inc[gdc_pkg::DAY_W-1:0];
    month_next = work_month;
    year_next  = work_year;
    if (day_inc > {1'b0, month_len}) begin
      day_next = 5'd1;
      if (month_inc > gdc_pkg::MONTH_LAST) begin
        month_next = gdc_pkg::MONTH_JAN;
        year_next  = work_year + 14'd1;
      end else begin
        month_next = month_inc[gdc_pkg::MONTH_W-1:0];
      end
    end
  end

  always_comb begin
    ordinal = gdc_pkg::CUM_DAYS[cur_month] + 9'(cur_day);
    if (cur_leap && (cur_month > gdc_pkg::MONTH_FEB)) begin
      ordinal = ordinal + 9'd1;
    end
    earlier = {cur_year, cur_month, cur_day} < {cmp_year, cmp_month, cmp_day};
    same    = {cur_year, cur_month, cur_day} == {cmp_year, cmp_month, cmp_day};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_day   <= gdc_pkg::RESET_DAY;
      cur_month <= gdc_pkg::RESET_MONTH;
      cur_year  <= gdc_pkg::RESET_YEAR;
      days_left <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gdc_pkg::CFG_START_DAY:   cur_day   <= cfg_data[gdc_pkg::DAY_W-1:0];
          gdc_pkg::CFG_START_MONTH: cur_month <= cfg_data[gdc_pkg::MONTH_W-1:0];
          gdc_pkg::CFG_START_YEAR:  cur_year  <= cfg_data[gdc_pkg::YEAR_W-1:0];
          default: begin
          end
        endcase
      end else if (cmd.commit && !peek) begin
        cur_day   <= work_day;
        cur_month <= work_month;
        cur_year  <= work_year;
      end
      if (cmd.load) begin
        days_left <= req_word.days_offset;
      end else if (cmd.step) begin
        days_left <= days_left - 16'd1;
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_leap  <= gdc_pkg::is_leap(cur_year);
    work_leap <= gdc_pkg::is_leap(work_year);
    if (cmd.load) begin
      work_day   <= cur_day;
      work_month <= cur_month;
      work_year  <= cur_year;
      peek       <= req_word.req_type;
      cmp_day    <= req_word.cmp_day;
      cmp_month  <= req_word.cmp_month;
      cmp_year   <= req_word.cmp_year;
    end else if (cmd.step) begin
      work_day   <= day_next;
      work_month <= month_next;
      work_year  <= year_next;
    end
    if (cmd.emit) begin
      rsp_word.res_day     <= work_day;
      rsp_word.res_month   <= work_month;
      rsp_word.res_year    <= work_year;
      rsp_word.day_of_year <= ordinal;
      rsp_word.is_earlier  <= earlier;
      rsp_word.is_same     <= same;
    end
  end

  assign status.days_zero = (days_left == '0);
  assign status.out_free  = !rsp_valid || !rsp_stall;

endmodule

// ----- hw/rtl/gregorian_date_calendar_unit.sv -----
// ----------------------------------------------------------------------------
// gregorian_date_calendar_unit
// Gregorian date keeper: adds a day offset to a stored date, optionally
// storing the result, and reports day of year and a date comparison.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req_word) takes one word per
//   item; the response channel (rsp_valid, rsp_stall, rsp_word) returns one
//   word per item, in order. The config port (cfg_we, cfg_index, cfg_data)
//   writes start day, month or year and loads it into the stored date at
//   once; write it only while no item is in flight.
//   An item is stepped one day per clock by a single increment unit; a new
//   request is taken in the cycle after the previous response has been
//   loaded into the output register.
//   While the receiver stalls, the response word holds; the next item still
//   runs and waits in its result state until the output register frees up.
//   Synchronous reset sets the stored date to 1/1/2000, empties the output
//   and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module gregorian_date_calendar_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gdc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  gdc_pkg::req_t                 req_word,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output gdc_pkg::rsp_t                 rsp_word
);

  gdc_pkg::dp_cmd_t    cmd;
  gdc_pkg::dp_status_t status;

  gdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gdc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ----- tb/gregorian_date_calendar_unit_tb.sv -----
// ----------------------------------------------------------------------------
// gregorian_date_calendar_unit_tb
// Self-checking bench for the date unit. A scoreboard class tracks its own
// copy of the stored date and predicts every response word. The bench opens
// with directed dates (leap rules, year wrap, out-of-range months and days,
// the largest offsets) and then runs random phases, each from a new start
// date. Both channels idle at random, and one phase holds the response side
// off long enough to back the unit up into its request channel.
// ----------------------------------------------------------------------------
module gregorian_date_calendar_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_ADVANCE = 1'b0;
  localparam logic REQ_PEEK    = 1'b1;
  localparam logic [gdc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES  = 12;
  localparam int HOLDOFF_LEN   = 300;

  // Year first so that comparing two packed dates orders them by calendar.
  typedef struct packed {
    logic [gdc_pkg::YEAR_W-1:0]  year;
    logic [gdc_pkg::MONTH_W-1:0] month;
    logic [gdc_pkg::DAY_W-1:0]   day;
  } cal_date_t;

  class calendar_scoreboard;
    cal_date_t     stored;
    gdc_pkg::rsp_t expected_q[$];
    int            errors;

    function new();
      stored = '{year: gdc_pkg::RESET_YEAR, month: gdc_pkg::RESET_MONTH,
                 day: gdc_pkg::RESET_DAY};
      errors = 0;
    endfunction

    function bit leap_year(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Months outside 1..12 are treated as 31 days long.
    function int month_length(int m, int y);
      if (m < 1 || m > 12) return 31;
      case (m)
        2:           return leap_year(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:     return 31;
      endcase
    endfunction

    function cal_date_t add_days(cal_date_t base, int n);
      int d, m, y;
      cal_date_t r;
      d = base.day;
      m = base.month;
      y = base.year;
      repeat (n) begin
        d++;
        if (d > month_length(m, y)) begin
          d = 1;
          m++;
          if (m > 12) begin
            m = 1;
            y = (y + 1) % (1 << gdc_pkg::YEAR_W);
          end
        end
      end
      r.day   = d[gdc_pkg::DAY_W-1:0];
      r.month = m[gdc_pkg::MONTH_W-1:0];
      r.year  = y[gdc_pkg::YEAR_W-1:0];
      return r;
    endfunction

    function logic [gdc_pkg::ORD_W-1:0] day_count(cal_date_t dt);
      int sum;
      sum = dt.day;
      for (int k = 1; k < dt.month; k++) sum += month_length(k, dt.year);
      return sum[gdc_pkg::ORD_W-1:0];
    endfunction

    function cal_date_t stored_after(gdc_pkg::req_t r);
      if (r.req_type == REQ_PEEK) return stored;
      return add_days(stored, r.days_offset);
    endfunction

    function void load_start(logic [gdc_pkg::CFG_IDX_W-1:0] idx,
                             logic [gdc_pkg::CFG_W-1:0] data);
      case (idx)
        gdc_pkg::CFG_START_DAY:   stored.day   = data[gdc_pkg::DAY_W-1:0];
        gdc_pkg::CFG_START_MONTH: stored.month = data[gdc_pkg::MONTH_W-1:0];
        gdc_pkg::CFG_START_YEAR:  stored.year  = data[gdc_pkg::YEAR_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(gdc_pkg::req_t r);
      cal_date_t target, cmp;
      gdc_pkg::rsp_t e;
      target = add_days(stored, r.days_offset);
      if (r.req_type == REQ_ADVANCE) stored = target;
      cmp = '{year: r.cmp_year, month: r.cmp_month, day: r.cmp_day};
      e.res_day     = target.day;
      e.res_month   = target.month;
      e.res_year    = target.year;
      e.day_of_year = day_count(stored);
      e.is_earlier  = stored < cmp;
      e.is_same     = stored == cmp;
      expected_q.push_back(e);
    endfunction

    function void check_field(string name, logic [15:0] exp, logic [15:0] act);
      if (exp !== act) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_response(gdc_pkg::rsp_t got);
      gdc_pkg::rsp_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: response word %h with nothing outstanding", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      check_field("res_day", e.res_day, got.res_day);
      check_field("res_month", e.res_month, got.res_month);
      check_field("res_year", e.res_year, got.res_year);
      check_field("day_of_year", e.day_of_year, got.day_of_year);
      check_field("is_earlier", e.is_earlier, got.is_earlier);
      check_field("is_same", e.is_same, got.is_same);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [gdc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gdc_pkg::CFG_W-1:0]     cfg_data;
  logic                          req_valid;
  logic                          req_stall;
  gdc_pkg::req_t                 req_word;
  logic                          rsp_valid;
  logic                          rsp_stall;
  gdc_pkg::rsp_t                 rsp_word;

  calendar_scoreboard sb = new();
  int idle_pct = 21;
  int holdoff_asked = 0;
  int holdoff_served = 0;

  gregorian_date_calendar_unit uut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .req_valid, .req_stall, .req_word,
    .rsp_valid, .rsp_stall, .rsp_word
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("gregorian_date_calendar_unit_tb: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req_word);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp_word);
    end
  end

  // Response side: random stalls, plus a long hold-off whenever one is asked.
  initial begin : receiver
    int hold;
    hold = 0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_served != holdoff_asked) begin
        holdoff_served++;
        hold = HOLDOFF_LEN;
      end
      if (hold > 0) begin
        hold--;
        rsp_stall = 1'b1;
      end else begin
        rsp_stall = ($urandom_range(99) < idle_pct);
      end
    end
  end

  function automatic gdc_pkg::req_t make_req(logic kind, int offset, int cd, int cm,
                                             int cy);
    gdc_pkg::req_t r;
    r.req_type    = kind;
    r.days_offset = gdc_pkg::OFFSET_W'(offset);
    r.cmp_day     = gdc_pkg::DAY_W'(cd);
    r.cmp_month   = gdc_pkg::MONTH_W'(cm);
    r.cmp_year    = gdc_pkg::YEAR_W'(cy);
    return r;
  endfunction

  // Entered and left at a falling edge; valid stays high on the way out.
  task automatic offer(input gdc_pkg::req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req_word  = r;
    forever begin
      @(posedge clk);
      if (!req_stall) break;
    end
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [gdc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gdc_pkg::CFG_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.load_start(idx, data);
  endtask

  task automatic set_start(input int d, input int m, input int y);
    drain();
    cfg_write(gdc_pkg::CFG_START_DAY, gdc_pkg::CFG_W'(d));
    cfg_write(gdc_pkg::CFG_START_MONTH, gdc_pkg::CFG_W'(m));
    cfg_write(gdc_pkg::CFG_START_YEAR, gdc_pkg::CFG_W'(y));
  endtask

  // Mostly real dates, biased toward month ends and tricky years; the rest
  // carry any day and month value the fields can hold.
  task automatic random_start();
    int d, m, y, len;
    m = $urandom_range(12, 1);
    case ($urandom_range(3))
      0:       y = $urandom_range(16383, 16379);
      1:       y = 100 * $urandom_range(163);
      2:       y = $urandom_range(16383);
      default: y = $urandom_range(2110, 1890);
    endcase
    len = sb.month_length(m, y);
    d = ($urandom_range(1)) ? len - $urandom_range(2) : $urandom_range(len, 1);
    if ($urandom_range(9) < 2) begin
      d = $urandom_range(31);
      m = $urandom_range(15);
    end
    set_start(d, m, y);
  endtask

  function automatic gdc_pkg::req_t random_req();
    gdc_pkg::req_t r;
    cal_date_t goal;
    int pick;
    r.req_type = ($urandom_range(99) < 60) ? REQ_ADVANCE : REQ_PEEK;
    pick = $urandom_range(99);
    if (pick < 60)      r.days_offset = gdc_pkg::OFFSET_W'($urandom_range(31));
    else if (pick < 90) r.days_offset = gdc_pkg::OFFSET_W'($urandom_range(400, 32));
    else if (pick < 98) r.days_offset = gdc_pkg::OFFSET_W'($urandom_range(2000, 401));
    else                r.days_offset = gdc_pkg::OFFSET_W'($urandom_range(4000, 2001));
    // Mostly aim the compare date at the stored date or one step off it, so
    // that the equal flag and both orderings at each field come up often.
    goal = sb.stored_after(r);
    pick = $urandom_range(99);
    if (pick < 55) begin
      if (pick >= 30) begin
        case ($urandom_range(5))
          0:       goal.day   = goal.day + 1'b1;
          1:       goal.day   = goal.day - 1'b1;
          2:       goal.month = goal.month + 1'b1;
          3:       goal.month = goal.month - 1'b1;
          4:       goal.year  = goal.year + 1'b1;
          default: goal.year  = goal.year - 1'b1;
        endcase
      end
      r.cmp_day   = goal.day;
      r.cmp_month = goal.month;
      r.cmp_year  = goal.year;
    end else begin
      r.cmp_day   = gdc_pkg::DAY_W'($urandom_range(31));
      r.cmp_month = gdc_pkg::MONTH_W'($urandom_range(15));
      r.cmp_year  = gdc_pkg::YEAR_W'($urandom_range(16383));
    end
    return r;
  endfunction

  initial begin : stimulus
    cfg_we    = 1'b0;
    cfg_index = gdc_pkg::CFG_START_DAY;
    cfg_data  = '0;
    req_valid = 1'b0;
    req_word  = '0;
    rst       = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset date, leap day of a year divisible by 400, the largest offsets.
    offer(make_req(REQ_PEEK, 0, 1, 1, 2000));
    offer(make_req(REQ_ADVANCE, 59, 0, 0, 0));
    offer(make_req(REQ_ADVANCE, 1, 31, 15, 16383));
    offer(make_req(REQ_PEEK, 65535, 1, 3, 2000));
    offer(make_req(REQ_ADVANCE, 32768, 0, 0, 0));

    // A century year that is not a leap year, and an ordinary leap year.
    set_start(28, 2, 1900);
    offer(make_req(REQ_ADVANCE, 1, 1, 3, 1900));
    set_start(28, 2, 2004);
    offer(make_req(REQ_ADVANCE, 1, 29, 2, 2004));

    // The last day of the top year wraps to year zero, which is a leap year.
    set_start(31, 12, 16383);
    offer(make_req(REQ_PEEK, 1, 31, 12, 16383));
    offer(make_req(REQ_ADVANCE, 1, 1, 1, 0));
    offer(make_req(REQ_ADVANCE, 59, 29, 2, 0));

    // Day zero and month zero.
    set_start(0, 0, 2023);
    offer(make_req(REQ_PEEK, 0, 0, 0, 2023));
    offer(make_req(REQ_ADVANCE, 1, 2, 0, 2023));
    offer(make_req(REQ_ADVANCE, 31, 1, 1, 2023));

    // Months above twelve.
    set_start(31, 15, 2023);
    offer(make_req(REQ_ADVANCE, 1, 1, 1, 2024));
    set_start(20, 13, 100);
    offer(make_req(REQ_PEEK, 12, 20, 14, 100));
    offer(make_req(REQ_ADVANCE, 12, 1, 1, 101));

    // A day past the end of its month rolls over on the next increment.
    set_start(31, 4, 2100);
    offer(make_req(REQ_ADVANCE, 1, 1, 5, 2100));

    // The spare register index must leave the stored date alone.
    drain();
    cfg_write(CFG_UNUSED, '1);
    offer(make_req(REQ_PEEK, 0, 1, 5, 2100));

    for (int phase = 0; phase < 10; phase++) begin
      random_start();
      idle_pct = (phase == 3) ? 0 : 21;
      if (phase == 6) holdoff_asked++;
      repeat (40) offer(random_req());
    end

    req_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("gregorian_date_calendar_unit_tb: done, clean");
    end else begin
      $display("gregorian_date_calendar_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
